// ----- design/assert_macros.svh -----
// Assertion helpers shared by the integral image block.
// RGII_ASSERT checks a property on every rising clock edge outside reset.
// RGII_NEVER checks that a condition never holds outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RGII_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");
`define RGII_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define RGII_ASSERT(lbl, clk, rstn, prop)
`define RGII_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- design/rgii_pkg.sv -----
package rgii_pkg;

    // Default size limits
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths
    localparam int CFG_W    = 11;
    localparam int PIX_W    = 24;
    localparam int GRAY_W   = 8;
    localparam int AREA_W   = 28;
    localparam int SQUARE_W = 36;
    localparam int SQ_W     = 2 * GRAY_W;
    localparam int WSUM_W   = 15;
    localparam int PROD_W   = WSUM_W + 13;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

    // Luma weights, in hundredths
    localparam logic [WSUM_W-1:0] W_RED   = WSUM_W'(30);
    localparam logic [WSUM_W-1:0] W_GREEN = WSUM_W'(59);
    localparam logic [WSUM_W-1:0] W_BLUE  = WSUM_W'(11);

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 2^15
    localparam logic [PROD_W-1:0] RECIP_100   = PROD_W'(5243);
    localparam int                RECIP_SHIFT = 19;

    // Configuration register indexes
    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Position flags of one pixel in the frame
    typedef struct packed
    {
        logic first;  // first pixel of its row
        logic top;    // pixel lies on the first row
        logic last;   // last pixel of the frame
    } pos_flags_t;

    // Weighted channel sum, 30R + 59G + 11B
    function automatic logic [WSUM_W-1:0] gray_weight(input logic [PIX_W-1:0] pix);
        logic [WSUM_W-1:0] r;
        logic [WSUM_W-1:0] g;
        logic [WSUM_W-1:0] b;
        r = WSUM_W'(pix[23:16]);
        g = WSUM_W'(pix[15:8]);
        b = WSUM_W'(pix[7:0]);
        return W_RED * r + W_GREEN * g + W_BLUE * b;
    endfunction

    // Divide the weighted sum by 100
    function automatic logic [GRAY_W-1:0] div100(input logic [WSUM_W-1:0] wsum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(wsum) * RECIP_100;
        return GRAY_W'(prod >> RECIP_SHIFT);
    endfunction

endpackage

// ----- design/rgii_line_mem.sv -----
module rgii_line_mem
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rgii_scan.sv -----
`include "assert_macros.svh"

module rgii_scan
    import rgii_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             step,
    output logic [COL_W-1:0] col,
    output pos_flags_t       flags
);

    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SZW_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int SZH_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [SZW_W-1:0] width_eff;
    logic [SZH_W-1:0] height_eff;
    logic             row_end;
    logic             frame_end;

    // Decode register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          width_next  = width_reg;
            endcase
        end
    end

    // Map zero or oversize settings to the limit
    always_comb
    begin
        if (width_reg == '0 || SZW_W'(width_reg) > SZW_W'(MAX_WIDTH))
        begin
            width_eff = SZW_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = SZW_W'(width_reg);
        end
        if (height_reg == '0 || SZH_W'(height_reg) > SZH_W'(MAX_HEIGHT))
        begin
            height_eff = SZH_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = SZH_W'(height_reg);
        end
    end

    // Detect row and frame ends
    assign row_end   = (SZW_W'(col_reg) + SZW_W'(1)) >= width_eff;
    assign frame_end = row_end && ((SZH_W'(row_reg) + SZH_W'(1)) >= height_eff);

    // Advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign col         = col_reg;
    assign flags.first = (col_reg == '0);
    assign flags.top   = (row_reg == '0);
    assign flags.last  = frame_end;

    `RGII_ASSERT(a_frame_wrap, clk, rst_n, step && frame_end |=> col_reg == '0 && row_reg == '0)
    `RGII_ASSERT(a_col_step, clk, rst_n, step && !row_end |=> col_reg == $past(col_reg) + COL_W'(1))
    `RGII_ASSERT(a_row_step, clk, rst_n, step && row_end && !frame_end |=> col_reg == '0 && row_reg == $past(row_reg) + ROW_W'(1))

endmodule

// ----- design/rgb_gray_integral_image.sv -----
// A request passes through stages 1, 2 and 3 and the output register to the output.
// Throughput: one pixel per cycle, while the output does not stall, for image widths of 4
// and more; for widths 1 to 3 a pixel waits until the pixel above it has been written
// back to the line buffer, set by the line buffer's read-modify-write.
// Reset clears counters, running sums and pipeline valids and sets 640 x 480;
// line buffers are not cleared, the first row does not use what it reads from them.
`include "assert_macros.svh"

module rgb_gray_integral_image
    import rgii_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  cfg_reg_t            cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [PIX_W-1:0]    pixel_rgb,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [GRAY_W-1:0]   gray_level,
    output logic [AREA_W-1:0]   area_sum,
    output logic [SQUARE_W-1:0] square_sum,
    output logic                frame_last
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RS_W   = $clog2(MAX_WIDTH * 255 + 1);
    localparam int RQ_W   = $clog2(MAX_WIDTH * 65025 + 1);
    localparam int LINE_W = AREA_W + SQUARE_W;

    logic               in_acc;
    logic               hazard;
    logic               en_out;
    logic               en3;
    logic               en2;
    logic               en1;
    logic [COL_W-1:0]   scan_col;
    pos_flags_t         scan_flags;
    logic [LINE_W-1:0]  mem_rdata;
    logic               mem_we;

    // Stage 1: weighted sum, line buffer read in flight
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    pos_flags_t         s1_flags_reg;
    logic [WSUM_W-1:0]  s1_wsum_reg;

    // Stage 2: gray level and value from the row above
    logic               s2_valid_reg;
    logic [COL_W-1:0]   s2_col_reg;
    pos_flags_t         s2_flags_reg;
    logic [GRAY_W-1:0]  s2_gray_reg;
    logic [AREA_W-1:0]  s2_above_sum_reg;
    logic [SQUARE_W-1:0] s2_above_sq_reg;

    // Stage 3: square and row running sum
    logic               s3_valid_reg;
    logic [COL_W-1:0]   s3_col_reg;
    pos_flags_t         s3_flags_reg;
    logic [GRAY_W-1:0]  s3_gray_reg;
    logic [SQ_W-1:0]    s3_sq_reg;
    logic [RS_W-1:0]    s3_rsum_reg;
    logic [AREA_W-1:0]  s3_above_sum_reg;
    logic [SQUARE_W-1:0] s3_above_sq_reg;

    // Row running sums
    logic [RS_W-1:0]    row_sum_reg;
    logic [RS_W-1:0]    row_sum_next;
    logic [RQ_W-1:0]    row_sq_reg;
    logic [RQ_W-1:0]    row_sq_next;

    // Output register
    logic               out_valid_reg;
    logic [GRAY_W-1:0]  out_gray_reg;
    logic [AREA_W-1:0]  out_area_reg;
    logic [SQUARE_W-1:0] out_square_reg;
    logic               out_last_reg;
    logic [AREA_W-1:0]  area_next;
    logic [SQUARE_W-1:0] square_next;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    // Stage enables, a stage moves when the one after it is empty or moving
    assign en_out   = !out_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en_out;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;

    // Interlock: hold a request whose column is still being updated in flight
    assign hazard = (s1_valid_reg && s1_col_reg == scan_col)
                 || (s2_valid_reg && s2_col_reg == scan_col)
                 || (s3_valid_reg && s3_col_reg == scan_col);
    assign in_ready = en1 && !hazard;
    assign in_acc   = in_valid && in_ready;

    rgii_scan
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (in_acc),
        .col       (scan_col),
        .flags     (scan_flags)
    );

    assign mem_we = s3_valid_reg && en_out;

    rgii_line_mem
    #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    )
    u_line_mem
    (
        .clk   (clk),
        .re    (in_acc),
        .raddr (scan_col),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (s3_col_reg),
        .wdata ({square_next, area_next})
    );

    // Running sums along the row, restart at the first pixel
    always_comb
    begin
        row_sum_next = (s2_flags_reg.first ? '0 : row_sum_reg) + RS_W'(s2_gray_reg);
        row_sq_next  = (s3_flags_reg.first ? '0 : row_sq_reg) + RQ_W'(s3_sq_reg);
        area_next    = s3_above_sum_reg + AREA_W'(s3_rsum_reg);
        square_next  = s3_above_sq_reg + SQUARE_W'(row_sq_next);
    end

    // Valid bits and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_sum_reg   <= '0;
            row_sq_reg    <= '0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_acc;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                begin
                    row_sum_reg <= row_sum_next;
                end
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg)
                begin
                    row_sq_reg <= row_sq_next;
                end
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_col_reg   <= scan_col;
            s1_flags_reg <= scan_flags;
            s1_wsum_reg  <= gray_weight(pixel_rgb);
        end
        if (en2)
        begin
            s2_col_reg   <= s1_col_reg;
            s2_flags_reg <= s1_flags_reg;
            s2_gray_reg  <= div100(s1_wsum_reg);
            if (s1_flags_reg.top)
            begin
                s2_above_sum_reg <= '0;
                s2_above_sq_reg  <= '0;
            end
            else
            begin
                s2_above_sum_reg <= mem_rdata[AREA_W-1:0];
                s2_above_sq_reg  <= mem_rdata[LINE_W-1:AREA_W];
            end
        end
        if (en3)
        begin
            s3_col_reg       <= s2_col_reg;
            s3_flags_reg     <= s2_flags_reg;
            s3_gray_reg      <= s2_gray_reg;
            s3_sq_reg        <= SQ_W'(s2_gray_reg) * SQ_W'(s2_gray_reg);
            s3_rsum_reg      <= row_sum_next;
            s3_above_sum_reg <= s2_above_sum_reg;
            s3_above_sq_reg  <= s2_above_sq_reg;
        end
        if (en_out)
        begin
            out_gray_reg   <= s3_gray_reg;
            out_area_reg   <= area_next;
            out_square_reg <= square_next;
            out_last_reg   <= s3_flags_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gray_level = out_gray_reg;
    assign area_sum   = out_area_reg;
    assign square_sum = out_square_reg;
    assign frame_last = out_last_reg;

    `RGII_NEVER(a_no_rw_collide, clk, rst_n, mem_we && in_acc && s3_col_reg == scan_col)
    `RGII_ASSERT(a_rdata_hold, clk, rst_n, s1_valid_reg && !en2 |=> $stable(mem_rdata))
    `RGII_ASSERT(a_row_restart, clk, rst_n, s2_valid_reg && en3 && s2_flags_reg.first |=> s3_rsum_reg == RS_W'(s3_gray_reg))

endmodule

// ----- tb/sv/rgii_checker.sv -----
module rgii_checker
    import rgii_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  cfg_reg_t            cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [PIX_W-1:0]    pixel_rgb,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [GRAY_W-1:0]   gray_level,
    input  logic [AREA_W-1:0]   area_sum,
    input  logic [SQUARE_W-1:0] square_sum,
    input  logic                frame_last,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH   = DEF_MAX_WIDTH;
    localparam int RED_WEIGHT   = 30;
    localparam int GREEN_WEIGHT = 59;
    localparam int BLUE_WEIGHT  = 11;
    localparam int PERCENT      = 100;
    localparam int MAX_REPORTS  = 40;

    typedef struct
    {
        bit [GRAY_W-1:0]   gray;
        bit [AREA_W-1:0]   area;
        bit [SQUARE_W-1:0] square;
        bit                last;
    } integral_res_t;

    // Integral values of the row above, one entry per column
    bit [AREA_W-1:0]   sum_above    [LINE_DEPTH];
    bit [SQUARE_W:0]   square_above [LINE_DEPTH];
    bit [17:0]         run_sum;
    bit [26:0]         run_square;
    int unsigned       col_pos;
    int unsigned       row_pos;
    bit [CFG_W-1:0]    width_reg;
    bit [CFG_W-1:0]    height_reg;
    integral_res_t     integral_q [$];
    integral_res_t     oldest;

    // Out-of-range sizes fall back to the maximum
    function automatic int unsigned active_dim(input bit [CFG_W-1:0] value, input int unsigned limit);
        if (value == 0 || value > limit)
            return limit;
        return value;
    endfunction

    // Gray level, rectangle sums and frame end for one pixel request
    function automatic integral_res_t predict_integral(input bit [PIX_W-1:0] pix);
        int unsigned     gray_val;
        int unsigned     w;
        int unsigned     h;
        int unsigned     col;
        bit [AREA_W-1:0] area_val;
        bit [SQUARE_W:0] square_val;
        bit              row_done;
        integral_res_t   res;
        gray_val = (RED_WEIGHT * int'(pix[23:16]) + GREEN_WEIGHT * int'(pix[15:8])
                    + BLUE_WEIGHT * int'(pix[7:0])) / PERCENT;
        w   = active_dim(width_reg, DEF_MAX_WIDTH);
        h   = active_dim(height_reg, DEF_MAX_HEIGHT);
        col = col_pos % LINE_DEPTH;
        run_sum    = run_sum + 18'(gray_val);
        run_square = run_square + 27'(gray_val * gray_val);
        area_val   = AREA_W'(run_sum);
        square_val = (SQUARE_W + 1)'(run_square);
        // First row of a frame has nothing above it
        if (row_pos > 0)
        begin
            area_val   = area_val + sum_above[col];
            square_val = square_val + square_above[col];
        end
        sum_above[col]    = area_val;
        square_above[col] = square_val;
        row_done   = (col_pos + 1 >= w);
        res.gray   = GRAY_W'(gray_val);
        res.area   = area_val;
        res.square = square_val[SQUARE_W-1:0];
        res.last   = row_done && (row_pos + 1 >= h);
        // Advance the raster position
        if (row_done)
        begin
            col_pos    = 0;
            run_sum    = '0;
            run_square = '0;
            if (res.last)
                row_pos = 0;
            else
                row_pos++;
        end
        else
        begin
            col_pos++;
        end
        return res;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_sum    = '0;
            run_square = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            integral_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            // Check each result against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (integral_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: result with no request pending, expected none, %s %0d %0d",
                                 $time, "actual gray and area", gray_level, area_sum);
                    fail_count++;
                end
                else
                begin
                    oldest = integral_q.pop_front();
                    compare_field("gray_level", oldest.gray, gray_level);
                    compare_field("area_sum", oldest.area, area_sum);
                    compare_field("square_sum", oldest.square, square_sum);
                    compare_field("frame_last", oldest.last, frame_last);
                end
            end
            // Predict each accepted request
            if (in_valid && in_ready)
                integral_q.insert(integral_q.size(), predict_integral(pixel_rgb));
            pending = integral_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_rgb_gray_integral_image.sv -----
module tb_rgb_gray_integral_image
    import rgii_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1650;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 200;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_reg_t            cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [PIX_W-1:0]    pixel_rgb = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [GRAY_W-1:0]   gray_level;
    logic [AREA_W-1:0]   area_sum;
    logic [SQUARE_W-1:0] square_sum;
    logic                frame_last;
    int                  fail_count;
    int                  pending;

    // Raster position and sizes as the stimulus sees them
    int unsigned         pos_col    = 0;
    int unsigned         pos_row    = 0;
    logic [CFG_W-1:0]    cur_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0]    cur_height = RST_IMAGE_HEIGHT;
    int                  pix_sent   = 0;
    int                  pressure_asked = 0;
    int                  pressure_given = 0;
    int                  cycle_count    = 0;

    logic [PIX_W-1:0] corner_pix [6] = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                                         24'h00FF00, 24'h0000FF, 24'h808080};

    rgb_gray_integral_image dut (.*);

    rgii_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_rgb_gray_integral_image NOT OK");
            $finish;
        end
    end

    function automatic int unsigned active_size(input logic [CFG_W-1:0] value);
        if (value == 0 || value > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return value;
    endfunction

    function automatic void advance_position();
        if (pos_col + 1 >= active_size(cur_width))
        begin
            pos_col = 0;
            if (pos_row + 1 >= active_size(cur_height))
                pos_row = 0;
            else
                pos_row++;
        end
        else
        begin
            pos_col++;
        end
    endfunction

    // Pixels still needed to close the current frame
    function automatic int unsigned pixels_left();
        int unsigned w;
        int unsigned h;
        int unsigned row_left;
        int unsigned rows_after;
        w          = active_size(cur_width);
        h          = active_size(cur_height);
        row_left   = (pos_col + 1 >= w) ? 1 : w - pos_col;
        rows_after = (pos_row + 1 >= h) ? 0 : h - pos_row - 1;
        return row_left + rows_after * w;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        if ($urandom_range(0, 9) == 0)
            return corner_pix[$urandom_range(0, 5)];
        return PIX_W'($urandom_range(0, 24'hFFFFFF));
    endfunction

    function automatic int item_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CFG_W-1:0] extreme_size();
        case ($urandom_range(0, 3))
            0:       return CFG_W'(0);
            1:       return CFG_W'(1024);
            2:       return CFG_W'(1025);
            default: return CFG_W'(2047);
        endcase
    endfunction

    task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cur_width = value;
        else
            cur_height = value;
        @(negedge clk);
    endtask

    // Offer one pixel request after an optional gap and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        pixel_rgb <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        pix_sent++;
        advance_position();
    endtask

    task automatic close_burst();
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_burst(input int count, input bit steady);
        for (int i = 0; i < count; i++)
            send_pixel(random_pixel(), item_gap(steady));
        close_burst();
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side: random stalls, free-running stretches and long holds on request
    initial
    begin
        int stall_left;
        int free_left;
        int hold_left;
        int r;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (pressure_given < pressure_asked)
            begin
                pressure_given++;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (free_left > 0)
                begin
                    free_left--;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        free_left = $urandom_range(20, 80);
                    else if (r < 35)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 38)
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Request side: directed frames, then random frames with resizes
    initial
    begin
        int unsigned w_now;
        int unsigned w_cap;
        int          count;
        bit          steady;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Small frame with channel extremes, first row reads nothing above
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(3));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(2));
        foreach (corner_pix[i])
            send_pixel(corner_pix[i], 0);
        close_burst();
        drain();

        // One-pixel frames
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(1));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(1));
        send_pixel(24'hFFFFFF, 0);
        send_pixel(24'h000000, 0);
        close_burst();
        drain();

        // Zero and all-ones sizes act as maximum; shrink both mid frame
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(0));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(2047));
        send_burst(5, 1'b1);
        drain();
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(2));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(2));
        send_burst(3, 1'b1);
        drain();

        // One above the maximum; end the frame by resizing on the first row
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(1025));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(1025));
        send_burst(3, 1'b0);
        drain();
        write_cfg(REG_IMAGE_WIDTH, CFG_W'(4));
        write_cfg(REG_IMAGE_HEIGHT, CFG_W'(1));
        send_burst(1, 1'b0);
        drain();

        // Random frames
        while (pix_sent < ITEM_TARGET)
        begin
            drain();
            w_now = active_size(cur_width);
            if (pos_col == 0 && pos_row == 0)
            begin
                // Pick a new frame size, mostly small
                if ($urandom_range(0, 99) < 8)
                    write_cfg(REG_IMAGE_WIDTH, extreme_size());
                else if ($urandom_range(0, 99) < 30)
                    write_cfg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, 3)));
                else
                    write_cfg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(4, 16)));
                if ($urandom_range(0, 99) < 8)
                    write_cfg(REG_IMAGE_HEIGHT, extreme_size());
                else
                    write_cfg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 6)));
            end
            else if (w_now > 64 || active_size(cur_height) > 16 || $urandom_range(0, 5) == 0)
            begin
                // Resize mid frame; widen only on the first row so every read hits a written entry
                w_cap = (pos_row == 0 || w_now > 16) ? 16 : w_now;
                if (w_now > 64 || $urandom_range(0, 1) == 1)
                    write_cfg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, w_cap)));
                if (active_size(cur_height) > 16 || $urandom_range(0, 1) == 1)
                    write_cfg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 8)));
            end

            steady = ($urandom_range(0, 3) == 0);
            if (pressure_asked < 2 && pix_sent >= 300 + 800 * pressure_asked)
            begin
                // Keep offering while the result side holds off
                pressure_asked++;
                count  = 24;
                steady = 1'b1;
            end
            else if ($urandom_range(0, 99) < 75)
            begin
                count = pixels_left();
                if (count > 40)
                    count = 40;
            end
            else
            begin
                count = $urandom_range(1, 12);
            end
            send_burst(count, steady);
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_rgb_gray_integral_image OK");
        else
            $display("tb_rgb_gray_integral_image NOT OK");
        $finish;
    end

endmodule
